### rtl/priority_wait_queue_macros.svh
// Assertion macros shared by the priority wait queue RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef PRIORITY_WAIT_QUEUE_MACROS_SVH
`define PRIORITY_WAIT_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWQ_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PWQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pwq_pkg.sv
// Shared types, widths, command codes and cell operation codes for the
// priority wait queue. No dependencies.
package pwq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PRIORITY_BITS = 5;

    localparam int ID_W        = 8;
    localparam int CODE_W      = 2;
    localparam int CMD_W       = 2;
    localparam int PRIO_IN_W   = 5;
    localparam int COUNT_OUT_W = 5;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PRI_BIT_W   = (PRIORITY_BITS > 1) ? $clog2(PRIORITY_BITS) : 1;
    localparam int OP_W        = 3;

    typedef logic [ID_W-1:0]          t_id;
    typedef logic [PRIORITY_BITS-1:0] t_prio;
    typedef logic [CNT_W-1:0]         t_count;
    typedef logic [CODE_W-1:0]        t_code;
    typedef logic [CMD_W-1:0]         t_cmd;

    // Command codes on the input channel.
    localparam t_cmd CMD_ENQUEUE  = 2'd0;
    localparam t_cmd CMD_REMOVE   = 2'd1;
    localparam t_cmd CMD_WAKE_ONE = 2'd2;
    localparam t_cmd CMD_WAKE_ALL = 2'd3;

    // Operations broadcast to every cell of the chain.
    localparam logic [OP_W-1:0] OP_HOLD       = 3'd0;
    localparam logic [OP_W-1:0] OP_MARK_ID    = 3'd1;
    localparam logic [OP_W-1:0] OP_MARK_LIVE  = 3'd2;
    localparam logic [OP_W-1:0] OP_ELIM       = 3'd3;
    localparam logic [OP_W-1:0] OP_LOAD       = 3'd4;
    localparam logic [OP_W-1:0] OP_SHIFT_CAND = 3'd5;
    localparam logic [OP_W-1:0] OP_SHIFT_ALL  = 3'd6;

    // Control bundle broadcast from the sequencer to the cells.
    typedef struct packed {
        logic [OP_W-1:0]      op;
        t_id                  key_id;
        t_prio                key_prio;
        logic [PRI_BIT_W-1:0] bit_sel;
        logic                 any;
    } t_cell_ctl;

endpackage

### rtl/pwq_cell.sv
// One slot of the waiter chain: holds an id, a priority and a candidate flag.
// Depends on pwq_pkg for types and operation codes.
module pwq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pwq_pkg::t_cell_ctl i_ctl,
    input  logic               i_live,
    input  logic               i_tail,
    input  logic               i_prev_seen,
    input  pwq_pkg::t_id       i_next_id,
    input  pwq_pkg::t_prio     i_next_prio,
    output pwq_pkg::t_id       o_id,
    output pwq_pkg::t_prio     o_prio,
    output logic               o_seen,
    output logic               o_bit,
    output pwq_pkg::t_id       o_first_id
);
    import pwq_pkg::*;

    t_id   r_id;
    t_id   n_id;
    t_prio r_prio;
    t_prio n_prio;
    logic  r_cand;
    logic  n_cand;
    logic  first;

    // Prefix of candidates from the head down to this cell.
    assign o_seen     = i_prev_seen | r_cand;
    assign first      = r_cand & ~i_prev_seen;
    assign o_bit      = r_cand & r_prio[i_ctl.bit_sel];
    assign o_first_id = first ? r_id : '0;
    assign o_id       = r_id;
    assign o_prio     = r_prio;

    // Next state of the slot for the broadcast operation.
    always_comb begin
        n_id   = r_id;
        n_prio = r_prio;
        n_cand = r_cand;
        unique case (i_ctl.op)
            OP_HOLD: begin
            end
            OP_MARK_ID: begin
                n_cand = i_live && (r_id == i_ctl.key_id);
            end
            OP_MARK_LIVE: begin
                n_cand = i_live;
            end
            OP_ELIM: begin
                n_cand = r_cand && (r_prio[i_ctl.bit_sel] || !i_ctl.any);
            end
            OP_LOAD: begin
                if (i_tail) begin
                    n_id   = i_ctl.key_id;
                    n_prio = i_ctl.key_prio;
                end
            end
            OP_SHIFT_CAND: begin
                if (o_seen) begin
                    n_id   = i_next_id;
                    n_prio = i_next_prio;
                end
            end
            OP_SHIFT_ALL: begin
                n_id   = i_next_id;
                n_prio = i_next_prio;
            end
            default: begin
            end
        endcase
    end

    // Slot payload needs no reset; the candidate flag does.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= 1'b0;
        end else begin
            r_cand <= n_cand;
        end
        r_id   <= n_id;
        r_prio <= n_prio;
    end

endmodule

### rtl/priority_wait_queue.sv
// Priority wait queue: arrival-ordered waiters with priorities, FIFO tie-break.
// Input channel i_in_valid/o_in_ready carries a command, a waiter id, a
// priority and a wake code; output channel o_out_valid/i_out_ready carries
// success, woken waiter, wake code, queue count and a last marker per beat.
// One command is worked at a time; o_in_ready is high only while idle, and a
// result beat may still wait in the output register when the next command is
// accepted. Steps per command, from acceptance to the result beat: enqueue
// and remove mark the slot holding the waiter id on acceptance, then update
// the chain and load the beat; wake-one marks the live slots on acceptance,
// narrows the candidates in the cell chain once per priority bit, then picks
// the earliest candidate and closes the gap. Wake-all gives one beat per
// cycle while the receiver takes them, oldest waiter first, with last on the
// final beat. Remove, wake-one and wake-all on an empty queue give one beat
// with success low. A stalled receiver holds the sequencer at its result
// step, so nothing is lost or repeated. Reset (synchronous, active low)
// empties the queue and drops any pending beat; it needs no clearing pass.
// Depends on pwq_pkg, pwq_cell and priority_wait_queue_macros.svh.
`include "priority_wait_queue_macros.svh"

module priority_wait_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [pwq_pkg::CMD_W-1:0]     i_command,
    input  logic [pwq_pkg::ID_W-1:0]      i_waiter_id,
    input  logic [pwq_pkg::PRIO_IN_W-1:0] i_waiter_priority,
    input  logic [pwq_pkg::CODE_W-1:0]    i_wake_code,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_success,
    output logic                         o_woken_valid,
    output logic [pwq_pkg::ID_W-1:0]      o_woken_id,
    output logic [pwq_pkg::CODE_W-1:0]    o_woken_code,
    output logic [pwq_pkg::COUNT_OUT_W-1:0] o_queue_count,
    output logic                         o_last
);
    import pwq_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ENQ  = 3'd1;
    localparam logic [2:0] ST_REM  = 3'd2;
    localparam logic [2:0] ST_ELIM = 3'd3;
    localparam logic [2:0] ST_WALL = 3'd4;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    t_cmd                 r_cmd;
    t_cmd                 n_cmd;
    t_id                  r_key_id;
    t_id                  n_key_id;
    t_prio                r_key_prio;
    t_prio                n_key_prio;
    t_code                r_code;
    t_code                n_code;
    logic [PRI_BIT_W-1:0] r_bit;
    logic [PRI_BIT_W-1:0] n_bit;
    t_count               r_count;
    t_count               n_count;

    logic                   r_out_valid;
    logic                   n_out_valid;
    logic                   r_out_success;
    logic                   n_out_success;
    logic                   r_out_woken;
    logic                   n_out_woken;
    t_id                    r_out_id;
    t_id                    n_out_id;
    t_code                  r_out_code;
    t_code                  n_out_code;
    logic [COUNT_OUT_W-1:0] r_out_count;
    logic [COUNT_OUT_W-1:0] n_out_count;
    logic                   r_out_last;
    logic                   n_out_last;

    t_cell_ctl              ctl;
    logic                   out_free;
    logic                   out_load;
    logic                   hit;
    logic                   ok;
    logic                   woken;
    t_id                    first_any;
    t_id                    cell_id   [QUEUE_DEPTH];
    t_prio                  cell_prio [QUEUE_DEPTH];
    t_id                    next_id   [QUEUE_DEPTH];
    t_prio                  next_prio [QUEUE_DEPTH];
    t_id                    first_id  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]   seen;
    logic [QUEUE_DEPTH-1:0] cand_bit;

    // Chain of slots; each cell looks at its successor and the prefix above.
    assign seen[0] = 1'b0;
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        if (gi == QUEUE_DEPTH - 1) begin : g_end
            assign next_id[gi]   = '0;
            assign next_prio[gi] = '0;
        end else begin : g_mid
            assign next_id[gi]   = cell_id[gi+1];
            assign next_prio[gi] = cell_prio[gi+1];
        end

        pwq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_live      (CNT_W'(gi) < r_count),
            .i_tail      (CNT_W'(gi) == r_count),
            .i_prev_seen (seen[gi]),
            .i_next_id   (next_id[gi]),
            .i_next_prio (next_prio[gi]),
            .o_id        (cell_id[gi]),
            .o_prio      (cell_prio[gi]),
            .o_seen      (seen[gi+1]),
            .o_bit       (cand_bit[gi]),
            .o_first_id  (first_id[gi])
        );
    end

    assign hit = seen[QUEUE_DEPTH];

    // Id of the earliest candidate; all other cells drive zero.
    always_comb begin
        first_any = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            first_any = first_any | first_id[k];
        end
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    // Sequencer: issues one cell operation per cycle and builds result beats.
    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_key_id      = r_key_id;
        n_key_prio    = r_key_prio;
        n_code        = r_code;
        n_bit         = r_bit;
        n_count       = r_count;
        out_load      = 1'b0;
        ok            = 1'b0;
        woken         = 1'b0;
        n_out_success = r_out_success;
        n_out_woken   = r_out_woken;
        n_out_id      = r_out_id;
        n_out_code    = r_out_code;
        n_out_last    = r_out_last;

        ctl.op       = OP_HOLD;
        ctl.key_id   = (r_state == ST_IDLE) ? i_waiter_id : r_key_id;
        ctl.key_prio = r_key_prio;
        ctl.bit_sel  = r_bit;
        ctl.any      = |cand_bit;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd      = i_command;
                    n_key_id   = i_waiter_id;
                    n_key_prio = t_prio'(i_waiter_priority);
                    n_code     = i_wake_code;
                    unique case (i_command)
                        CMD_ENQUEUE: begin
                            ctl.op  = OP_MARK_ID;
                            n_state = ST_ENQ;
                        end
                        CMD_REMOVE: begin
                            ctl.op  = OP_MARK_ID;
                            n_state = ST_REM;
                        end
                        CMD_WAKE_ONE: begin
                            ctl.op  = OP_MARK_LIVE;
                            n_bit   = PRI_BIT_W'(PRIORITY_BITS - 1);
                            n_state = ST_ELIM;
                        end
                        CMD_WAKE_ALL: begin
                            n_state = ST_WALL;
                        end
                    endcase
                end
            end
            ST_ELIM: begin
                ctl.op = OP_ELIM;
                if (r_bit == '0) begin
                    n_state = ST_REM;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            ST_ENQ: begin
                if (out_free) begin
                    ok = !hit && (r_count < CNT_W'(QUEUE_DEPTH));
                    if (ok) begin
                        ctl.op  = OP_LOAD;
                        n_count = r_count + 1'b1;
                    end
                    out_load      = 1'b1;
                    n_out_success = ok;
                    n_out_woken   = 1'b0;
                    n_out_id      = '0;
                    n_out_code    = '0;
                    n_out_last    = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_REM: begin
                if (out_free) begin
                    if (hit) begin
                        ctl.op  = OP_SHIFT_CAND;
                        n_count = r_count - 1'b1;
                    end
                    woken         = hit && (r_cmd == CMD_WAKE_ONE);
                    out_load      = 1'b1;
                    n_out_success = hit;
                    n_out_woken   = woken;
                    n_out_id      = woken ? first_any : '0;
                    n_out_code    = woken ? r_code : '0;
                    n_out_last    = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_WALL: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_count == '0) begin
                        n_out_success = 1'b0;
                        n_out_woken   = 1'b0;
                        n_out_id      = '0;
                        n_out_code    = '0;
                        n_out_last    = 1'b1;
                        n_state       = ST_IDLE;
                    end else begin
                        ctl.op        = OP_SHIFT_ALL;
                        n_count       = r_count - 1'b1;
                        n_out_success = 1'b1;
                        n_out_woken   = 1'b1;
                        n_out_id      = cell_id[0];
                        n_out_code    = r_code;
                        n_out_last    = (r_count == CNT_W'(1));
                        if (r_count == CNT_W'(1)) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_count = out_load ? COUNT_OUT_W'(n_count) : r_out_count;
        n_out_valid = out_load || (r_out_valid && !i_out_ready);
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_key_id      <= n_key_id;
        r_key_prio    <= n_key_prio;
        r_code        <= n_code;
        r_bit         <= n_bit;
        r_out_success <= n_out_success;
        r_out_woken   <= n_out_woken;
        r_out_id      <= n_out_id;
        r_out_code    <= n_out_code;
        r_out_count   <= n_out_count;
        r_out_last    <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_success     = r_out_success;
    assign o_woken_valid = r_out_woken;
    assign o_woken_id    = r_out_id;
    assign o_woken_code  = r_out_code;
    assign o_queue_count = r_out_count;
    assign o_last        = r_out_last;

    // Checks on the sequencer and the result beats.
    `PWQ_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH), "queue count over depth")
    `PWQ_ASSERT_IMP(a_woken_ok, o_out_valid && o_woken_valid, o_success, "woken beat without success")
    `PWQ_ASSERT_IMP(a_mid_beat, o_out_valid && !o_last, r_state == ST_WALL, "non-last beat outside wake-all")
    `PWQ_ASSERT_NEXT(a_elim_flow, r_state == ST_ELIM, r_state == ST_ELIM || r_state == ST_REM, "priority narrowing left early")

endmodule
